/* rtl/reed_solomon_parity_generator_assert.svh */
// Assertion macros for the Reed-Solomon parity generator.
// No dependencies; included by the top level.
`ifndef REED_SOLOMON_PARITY_GENERATOR_ASSERT_SVH
`define REED_SOLOMON_PARITY_GENERATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RSP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define RSP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/rsp_pkg.sv */
// Shared types, constants and GF(2^8) arithmetic for the parity generator.
// No dependencies.
package rsp_pkg;

    localparam int CFG_W = 5;
    localparam int PARITY_RESET = 24;
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic busy;
        logic clear;
    } t_gen_status;

    function automatic t_byte gf_xtime(t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    function automatic t_byte gf_mul(t_byte a, t_byte b);
        t_byte acc;
        t_byte x;
        acc = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

/* rtl/rsp_in_if.sv */
// Request channel for message bytes: valid/ready handshake plus payload.
// No dependencies.
interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

/* rtl/rsp_out_if.sv */
// Request channel for parity bytes: valid/ready handshake plus payload.
// No dependencies.
interface rsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       parity_final;

    modport source (output valid, output parity_byte, output parity_final, input ready);
    modport sink   (input valid, input parity_byte, input parity_final, output ready);
endinterface

/* rtl/reed_solomon_parity_generator.sv */
// Systematic Reed-Solomon parity generator over GF(2^8), field polynomial 0x11D.
// Depends on rsp_pkg, rsp_in_if, rsp_out_if, rsp_gen and the assertion header.
//
//   channel   dir  payload                      handshake
//   i_in      in   data_byte, block_end          valid/ready
//   o_out     out  parity_byte, parity_final     valid/ready
//   i_cfg     in   parity_count (5 bits)         write enable, no wait
//
// One message byte per cycle unless rebuilding or a block-end byte waits; an accepted byte
// is registered in r_in_data before it reaches the remainder. Parity bytes leave one per
// cycle while o_out.ready holds, from a shift register that the block-end byte loads;
// a block-end byte waits while earlier parity drains. After reset or a configuration
// write the generator is rebuilt (degree 24 after reset); no request is accepted meanwhile.
`include "reed_solomon_parity_generator_assert.svh"

module reed_solomon_parity_generator #(
    parameter int MAX_PARITY = 30
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rsp_in_if.sink                    i_in,
    rsp_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [rsp_pkg::CFG_W-1:0] i_cfg_data
);
    import rsp_pkg::*;

    localparam int DW = $clog2(MAX_PARITY + 1);

    function automatic logic [DW-1:0] clamp_degree(logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (int'(v) > MAX_PARITY) begin
            return DW'(MAX_PARITY);
        end
        return DW'(v);
    endfunction

    logic [DW-1:0]             r_degree;
    t_byte [MAX_PARITY-1:0]    coeffs;
    t_gen_status               gen_status;

    logic                      r_in_valid;
    t_byte                     r_in_data;
    logic                      r_in_end;

    t_byte [MAX_PARITY-1:0]    r_rem;
    t_byte [MAX_PARITY-1:0]    n_rem;
    t_byte [MAX_PARITY-1:0]    r_par;
    logic [DW-1:0]             r_out_left;
    t_byte                     factor;

    logic in_fire;
    logic out_fire;
    logic out_free;
    logic consume;
    logic load;

    rsp_gen #(
        .MAX_PARITY (MAX_PARITY),
        .DW         (DW)
    ) u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cfg_we),
        .i_degree (r_degree),
        .o_coeffs (coeffs),
        .o_status (gen_status)
    );

    assign out_fire = o_out.valid && o_out.ready;
    assign out_free = (r_out_left == '0) || ((r_out_left == DW'(1)) && o_out.ready);
    assign consume  = r_in_valid && (!r_in_end || out_free);
    assign load     = consume && r_in_end;
    assign i_in.ready = !gen_status.busy && (!r_in_valid || consume);
    assign in_fire  = i_in.valid && i_in.ready;

    assign factor = r_in_data ^ r_rem[0];

    always_comb begin
        for (int j = 0; j < MAX_PARITY - 1; j++) begin
            n_rem[j] = gf_mul(coeffs[j], factor) ^ r_rem[j+1];
        end
        n_rem[MAX_PARITY-1] = gf_mul(coeffs[MAX_PARITY-1], factor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree   <= clamp_degree(CFG_W'(PARITY_RESET));
            r_in_valid <= 1'b0;
            r_out_left <= '0;
        end else begin
            if (i_cfg_we) begin
                r_degree <= clamp_degree(i_cfg_data);
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_out_left <= r_degree;
            end else if (out_fire) begin
                r_out_left <= r_out_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (gen_status.clear || load) begin
            r_rem <= '0;
        end else if (consume) begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_in.data_byte;
            r_in_end  <= i_in.block_end;
        end
        if (load) begin
            r_par <= n_rem;
        end else if (out_fire) begin
            for (int j = 0; j < MAX_PARITY - 1; j++) begin
                r_par[j] <= r_par[j+1];
            end
            r_par[MAX_PARITY-1] <= '0;
        end
    end

    assign o_out.valid        = (r_out_left != '0);
    assign o_out.parity_byte  = r_par[0];
    assign o_out.parity_final = (r_out_left == DW'(1));

    `RSP_ASSERT(a_load_when_free, i_clk, i_rst_n,
        !load || (r_out_left == '0) || ((r_out_left == DW'(1)) && out_fire),
        "parity shifter reloaded while bytes remain")
    `RSP_ASSERT(a_left_le_degree, i_clk, i_rst_n, r_out_left <= r_degree,
        "parity count exceeds degree")
    `RSP_ASSERT_NEXT(a_clear_on_build, i_clk, i_rst_n, gen_status.clear, r_rem == '0,
        "remainder not cleared on generator rebuild")

endmodule

/* rtl/rsp_gen.sv */
// Generator polynomial builder: one root multiplied in per cycle.
// Depends on rsp_pkg.
module rsp_gen #(
    parameter int MAX_PARITY = 30,
    parameter int DW         = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [DW-1:0]                       i_degree,
    output rsp_pkg::t_byte [MAX_PARITY-1:0]     o_coeffs,
    output rsp_pkg::t_gen_status                o_status
);
    import rsp_pkg::*;

    logic                      r_pending;
    logic [DW-1:0]             r_steps;
    logic [DW-1:0]             n_steps;
    t_byte [MAX_PARITY-1:0]    r_coeffs;
    t_byte [MAX_PARITY-1:0]    n_coeffs;
    t_byte                     r_root;
    t_byte                     n_root;

    always_comb begin
        n_coeffs = r_coeffs;
        n_root   = r_root;
        n_steps  = r_steps;
        if (r_pending) begin
            for (int j = 0; j < MAX_PARITY; j++) begin
                n_coeffs[j] = (DW'(j + 1) == i_degree) ? 8'h01 : 8'h00;
            end
            n_root  = 8'h01;
            n_steps = i_degree;
        end else if (r_steps != '0) begin
            for (int j = 0; j < MAX_PARITY - 1; j++) begin
                n_coeffs[j] = gf_mul(r_coeffs[j], r_root) ^ r_coeffs[j+1];
            end
            n_coeffs[MAX_PARITY-1] = gf_mul(r_coeffs[MAX_PARITY-1], r_root);
            n_root  = gf_xtime(r_root);
            n_steps = r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
            r_steps   <= '0;
        end else begin
            r_pending <= i_start;
            r_steps   <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coeffs <= n_coeffs;
        r_root   <= n_root;
    end

    assign o_coeffs       = r_coeffs;
    assign o_status.busy  = r_pending || (r_steps != '0);
    assign o_status.clear = r_pending;

endmodule
